FILE: rtl/mpts_pkg.sv
`default_nettype none
package mpts_pkg;

   localparam int ADDR_WIDTH  = 32;
   localparam int ERROR_LIMIT = 10;
   localparam int SLOT_COUNT  = 21;

   localparam logic [1:0] REQ_START      = 2'd0;
   localparam logic [1:0] REQ_WRITE_DONE = 2'd1;
   localparam logic [1:0] REQ_READ_DATA  = 2'd2;

   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   localparam logic [1:0] PH_FILL  = 2'd0;
   localparam logic [1:0] PH_READ  = 2'd1;
   localparam logic [1:0] PH_WORD  = 2'd2;
   localparam logic [1:0] PH_CHUNK = 2'd3;

   localparam logic [2:0] CSR_BASE    = 3'd0;
   localparam logic [2:0] CSR_LENGTH  = 3'd1;
   localparam logic [2:0] CSR_EN_BYTE = 3'd2;
   localparam logic [2:0] CSR_EN_HALF = 3'd3;
   localparam logic [2:0] CSR_EN_WORD = 3'd4;
   localparam logic [2:0] CSR_EN_CHK  = 3'd5;
   localparam logic [2:0] CSR_EN_CNT  = 3'd6;

   localparam logic [31:0] PAT_FILL = 32'h1234_5678;
   localparam logic [31:0] PAT_55   = 32'h5555_5555;
   localparam logic [31:0] PAT_AA   = 32'hAAAA_AAAA;

   localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_WIDTH) - 64'd1);

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] read_data;
   } item_type;

   typedef struct packed {
      logic [31:0] base_address;
      logic [26:0] region_length;
      logic        en_byte;
      logic        en_half;
      logic        en_word;
      logic        en_checker;
      logic        en_count;
   } cfg_type;

   function automatic logic [1:0] slot_size(input logic [4:0] s);
      if (s < 5'd12) return SIZE_BYTE;
      else if (s < 5'd18) return SIZE_HALF;
      else return SIZE_WORD;
   endfunction

   function automatic logic [1:0] slot_lane(input logic [4:0] s);
      logic [1:0] r;
      case (s)
         5'd0, 5'd1, 5'd2, 5'd12, 5'd13, 5'd14: r = 2'd0;
         5'd3, 5'd4, 5'd5, 5'd15, 5'd16, 5'd17: r = 2'd1;
         5'd6, 5'd7, 5'd8:                      r = 2'd2;
         5'd9, 5'd10, 5'd11:                    r = 2'd3;
         default:                               r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] slot_pattern(input logic [4:0] s);
      logic [1:0] r;
      case (s)
         5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18:  r = 2'd0;
         5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19: r = 2'd1;
         default:                                      r = 2'd2;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/mpts_queue.sv
`default_nettype none
module mpts_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  mpts_pkg::item_type    push_item,
   output logic                  full,
   input  wire                   pop,
   output logic                  head_valid,
   output mpts_pkg::item_type    head_item
);
   import mpts_pkg::*;

   item_type   data_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_item  = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> !pop) else $error("pop from empty queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 2'd1) else $error("count slip");

endmodule
`default_nettype wire

FILE: rtl/mpts_engine.sv
`default_nettype none
module mpts_engine (
   input  wire                   clock,
   input  wire                   reset,
   input  mpts_pkg::cfg_type     cfg,
   input  wire                   head_valid,
   input  mpts_pkg::item_type    head_item,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic [1:0]            rsp_command,
   output logic [31:0]           rsp_mem_address,
   output logic [1:0]            rsp_access_size,
   output logic [31:0]           rsp_write_value,
   output logic [31:0]           rsp_error_total
);
   import mpts_pkg::*;

   logic        busy_ff, busy_in;
   logic [1:0]  phase_ff, phase_in;
   logic [23:0] chunk_ff, chunk_in;
   logic [4:0]  sub_ff, sub_in;
   logic        rp_ff, rp_in;
   logic [31:0] exp_ff, exp_in;
   logic [31:0] err_ff, err_in;

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [31:0] addr_ff, addr_in;
   logic [1:0]  size_ff, size_in;
   logic [31:0] val_ff, val_in;
   logic [31:0] tot_ff, tot_in;

   logic [SLOT_COUNT-1:0] slot_mask;
   logic [24:0] wc;
   logic        can_load;

   assign wc       = cfg.region_length[26:2];
   assign can_load = !out_valid_ff || !rsp_stall;
   assign pop      = head_valid && can_load;

   always_comb begin
      logic [1:0] sz;
      logic [1:0] pt;
      logic       size_ok;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         sz = slot_size(5'(i));
         pt = slot_pattern(5'(i));
         size_ok = (sz == SIZE_BYTE) ? cfg.en_byte :
                   (sz == SIZE_HALF) ? cfg.en_half : cfg.en_word;
         slot_mask[i] = size_ok && ((pt < 2'd2) ? cfg.en_checker : cfg.en_count);
      end
   end

   function automatic logic [4:0] next_slot(input logic [SLOT_COUNT-1:0] m,
                                            input logic [4:0] from);
      logic [4:0] r;
      r = 5'(SLOT_COUNT);
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (m[i] && 5'(i) >= from) r = 5'(i);
      end
      return r;
   endfunction

   always_comb begin
      logic        cur_rd;
      logic [1:0]  cur_size;
      logic [31:0] got;
      logic        last;
      logic        done;
      logic        emit;
      logic        finish;
      logic        n_rd;
      logic [31:0] a;
      logic [31:0] rem;
      logic [1:0]  lane;
      logic [1:0]  pat;
      logic [31:0] v;
      logic [1:0]  s;

      busy_in  = busy_ff;
      phase_in = phase_ff;
      chunk_in = chunk_ff;
      sub_in   = sub_ff;
      rp_in    = rp_ff;
      exp_in   = exp_ff;
      err_in   = err_ff;
      done     = 1'b0;
      emit     = 1'b0;
      finish   = 1'b0;

      cur_rd   = (phase_ff == PH_FILL) ? 1'b0 : (phase_ff == PH_READ) ? 1'b1 : rp_ff;
      cur_size = (phase_ff == PH_CHUNK) ? slot_size(sub_ff) : SIZE_WORD;
      got      = (cur_size == SIZE_BYTE) ? {24'd0, head_item.read_data[7:0]} :
                 (cur_size == SIZE_HALF) ? {16'd0, head_item.read_data[15:0]} :
                 head_item.read_data;
      last     = ({1'b0, chunk_ff} + 25'd1) >= wc;

      if (pop) begin
         if (head_item.req_type == REQ_START) begin
            if (!busy_ff) begin
               err_in   = 32'd0;
               phase_in = PH_FILL;
               chunk_in = 24'd0;
               sub_in   = 5'd0;
               rp_in    = 1'b0;
               exp_in   = 32'd0;
               if (wc == 25'd0) begin
                  finish = 1'b1;
               end else begin
                  busy_in = 1'b1;
                  emit    = 1'b1;
               end
            end
         end else if (busy_ff && (head_item.req_type == REQ_WRITE_DONE ||
                                  head_item.req_type == REQ_READ_DATA) &&
                      ((head_item.req_type == REQ_READ_DATA) == cur_rd)) begin
            if (cur_rd && got != exp_ff && err_ff != 32'hFFFF_FFFF &&
                (phase_ff != PH_CHUNK || err_ff < 32'(ERROR_LIMIT))) begin
               err_in = err_ff + 32'd1;
            end
            if (phase_ff == PH_FILL || phase_ff == PH_READ) begin
               if (last) begin
                  phase_in = phase_ff + 2'd1;
                  chunk_in = 24'd0;
                  sub_in   = 5'd0;
                  rp_in    = 1'b0;
               end else begin
                  chunk_in = chunk_ff + 24'd1;
               end
            end else if (!rp_ff) begin
               rp_in = 1'b1;
            end else begin
               rp_in = 1'b0;
               if (phase_ff == PH_WORD) begin
                  if (sub_ff == 5'd0) begin
                     sub_in = 5'd1;
                  end else begin
                     sub_in = 5'd0;
                     if (!last) begin
                        chunk_in = chunk_ff + 24'd1;
                     end else begin
                        phase_in = PH_CHUNK;
                        chunk_in = 24'd0;
                        sub_in   = next_slot(slot_mask, 5'd0);
                        done     = sub_in >= 5'(SLOT_COUNT);
                     end
                  end
               end else begin
                  sub_in = next_slot(slot_mask, sub_ff + 5'd1);
                  if (sub_in >= 5'(SLOT_COUNT)) begin
                     if (last) begin
                        done = 1'b1;
                     end else begin
                        chunk_in = chunk_ff + 24'd1;
                        sub_in   = next_slot(slot_mask, 5'd0);
                        done     = sub_in >= 5'(SLOT_COUNT);
                     end
                  end
               end
            end
            if (done) finish = 1'b1;
            else emit = 1'b1;
         end
      end

      n_rd = (phase_in == PH_FILL) ? 1'b0 : (phase_in == PH_READ) ? 1'b1 : rp_in;
      a    = cfg.base_address + {6'd0, chunk_in, 2'b00};
      rem  = (32'(wc) - 32'(chunk_in)) << 2;
      lane = slot_lane(sub_in);
      pat  = slot_pattern(sub_in);
      s    = SIZE_WORD;
      v    = PAT_FILL;
      case (phase_in)
         PH_FILL, PH_READ: begin
            v = PAT_FILL;
         end
         PH_WORD: begin
            v = (sub_in == 5'd0) ? PAT_55 : PAT_AA;
         end
         PH_CHUNK: begin
            s = slot_size(sub_in);
            case (s)
               SIZE_BYTE: begin
                  a = a + {30'd0, lane};
                  v = (pat == 2'd0) ? 32'h55 : (pat == 2'd1) ? 32'hAA :
                      {24'd0, 8'(rem + 32'd4 - {30'd0, lane})};
               end
               SIZE_HALF: begin
                  a = a + {29'd0, lane, 1'b0};
                  v = (pat == 2'd0) ? 32'h5555 : (pat == 2'd1) ? 32'hAAAA :
                      {16'd0, 16'(rem + 32'd2 - {30'd0, lane})};
               end
               default: begin
                  v = (pat == 2'd0) ? PAT_55 : (pat == 2'd1) ? PAT_AA : rem;
               end
            endcase
         end
         default: begin
            v = PAT_FILL;
         end
      endcase

      cmd_in  = cmd_ff;
      addr_in = addr_ff;
      size_in = size_ff;
      val_in  = val_ff;
      tot_in  = tot_ff;
      out_valid_in = out_valid_ff && rsp_stall;

      if (finish) begin
         busy_in  = 1'b0;
         phase_in = PH_FILL;
         chunk_in = 24'd0;
         sub_in   = 5'd0;
         rp_in    = 1'b0;
         cmd_in   = CMD_FINISH;
         addr_in  = 32'd0;
         size_in  = SIZE_BYTE;
         val_in   = 32'd0;
         tot_in   = err_in;
         out_valid_in = 1'b1;
      end else if (emit) begin
         exp_in  = v;
         cmd_in  = n_rd ? CMD_READ : CMD_WRITE;
         addr_in = a & ADDR_MASK;
         size_in = s;
         val_in  = n_rd ? 32'd0 : v;
         tot_in  = err_in;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= PH_FILL;
         chunk_ff     <= 24'd0;
         sub_ff       <= 5'd0;
         rp_ff        <= 1'b0;
         exp_ff       <= 32'd0;
         err_ff       <= 32'd0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         chunk_ff     <= chunk_in;
         sub_ff       <= sub_in;
         rp_ff        <= rp_in;
         exp_ff       <= exp_in;
         err_ff       <= err_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      addr_ff <= addr_in;
      size_ff <= size_in;
      val_ff  <= val_in;
      tot_ff  <= tot_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_command     = cmd_ff;
   assign rsp_mem_address = addr_ff;
   assign rsp_access_size = size_ff;
   assign rsp_write_value = val_ff;
   assign rsp_error_total = tot_ff;

   a_finish_idles: assert property (@(posedge clock) disable iff (reset)
      (out_valid_in && can_load && cmd_in == CMD_FINISH) |=> !busy_ff)
      else $error("finish left engine busy");
   a_limit_holds: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CHUNK && err_ff >= 32'(ERROR_LIMIT) &&
       !(pop && head_item.req_type == REQ_START)) |=> $stable(err_ff))
      else $error("error count passed limit");
   a_no_pop_full: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |-> !pop) else $error("pop while output held");
   a_idle_response: assert property (@(posedge clock) disable iff (reset)
      (!busy_ff && pop && head_item.req_type != REQ_START) |=> !busy_ff)
      else $error("response woke idle engine");

endmodule
`default_nettype wire

FILE: rtl/memory_pattern_test_sequencer_top.sv
// Each req transfer is held in the queue, then its command in the engine output register.
// One req transfer per cycle while the queue is not full, at most one command per request.
// A 2-entry queue decouples request intake from the engine; the output register holds on stall.
// Reset (synchronous, active high) clears the queue, engine state, error count and config.
`default_nettype none
module memory_pattern_test_sequencer_top (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_stall,
   input  wire  [1:0]   req_type,
   input  wire  [31:0]  req_read_data,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output logic [1:0]   rsp_command,
   output logic [31:0]  rsp_mem_address,
   output logic [1:0]   rsp_access_size,
   output logic [31:0]  rsp_write_value,
   output logic [31:0]  rsp_error_total,
   input  wire          csr_write_enable,
   input  wire  [2:0]   csr_index,
   input  wire  [31:0]  csr_write_data
);
   import mpts_pkg::*;

   cfg_type  cfg_ff;
   item_type head_item;
   item_type push_item;
   logic     head_valid;
   logic     pop;
   logic     full;

   assign push_item = '{req_type: req_type, read_data: req_read_data};
   assign req_stall = full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BASE:    cfg_ff.base_address  <= csr_write_data;
            CSR_LENGTH:  cfg_ff.region_length <= csr_write_data[26:0];
            CSR_EN_BYTE: cfg_ff.en_byte       <= csr_write_data[0];
            CSR_EN_HALF: cfg_ff.en_half       <= csr_write_data[0];
            CSR_EN_WORD: cfg_ff.en_word       <= csr_write_data[0];
            CSR_EN_CHK:  cfg_ff.en_checker    <= csr_write_data[0];
            CSR_EN_CNT:  cfg_ff.en_count      <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   mpts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid && !full),
      .push_item  (push_item),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   mpts_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_command     (rsp_command),
      .rsp_mem_address (rsp_mem_address),
      .rsp_access_size (rsp_access_size),
      .rsp_write_value (rsp_write_value),
      .rsp_error_total (rsp_error_total)
   );

endmodule
`default_nettype wire

FILE: test/tb_memory_pattern_test_sequencer_top.sv
`timescale 1ns / 100ps
module tb_memory_pattern_test_sequencer_top;
   import mpts_pkg::*;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] mem_address;
      logic [1:0]  access_size;
      logic [31:0] write_value;
      logic [31:0] error_total;
   } command_type;

   typedef struct {
      bit          is_csr;
      logic [2:0]  idx;
      logic [31:0] val;
      logic [1:0]  rtype;
      logic [31:0] data;
      int          chk;
      command_type cmd;
   } row_type;

   localparam int CHK_PREDICT = 0;
   localparam int CHK_TYPED   = 1;
   localparam int CHK_NONE    = 2;
   localparam int NUM_SLOTS   = SLOT_COUNT;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = REQ_WRITE_DONE;
   logic [31:0] req_read_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_command;
   logic [31:0] rsp_mem_address;
   logic [1:0]  rsp_access_size;
   logic [31:0] rsp_write_value;
   logic [31:0] rsp_error_total;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_write_data = '0;

   memory_pattern_test_sequencer_top u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // sequencer mirror
   logic [31:0] m_base;
   logic [26:0] m_len;
   logic        m_en_byte, m_en_half, m_en_word, m_en_chk, m_en_cnt;
   logic        m_busy, m_read_pending;
   logic [1:0]  m_phase;
   logic [23:0] m_chunk;
   logic [4:0]  m_slot;
   logic [31:0] m_expected, m_errors;

   command_type cmd_q[$];
   int       failures = 0;
   int       cmd_items = 0;
   int       send_idle_pct = 28;
   int       stall_pct = 71;

   function automatic logic [31:0] word_total();
      return {7'd0, m_len[26:2]};
   endfunction

   function automatic logic [1:0] size_of(input int s);
      return s < 12 ? SIZE_BYTE : (s < 18 ? SIZE_HALF : SIZE_WORD);
   endfunction

   function automatic int lane_of(input int s);
      return s < 12 ? s / 3 : (s < 18 ? (s - 12) / 3 : 0);
   endfunction

   function automatic int pattern_of(input int s);
      return s < 12 ? s % 3 : (s < 18 ? (s - 12) % 3 : s - 18);
   endfunction

   function automatic bit slot_enabled(input int s);
      logic [1:0] sz;
      bit ok;
      if (s >= NUM_SLOTS) return 0;
      sz = size_of(s);
      ok = sz == SIZE_BYTE ? m_en_byte : (sz == SIZE_HALF ? m_en_half : m_en_word);
      if (!ok) return 0;
      return pattern_of(s) < 2 ? m_en_chk : m_en_cnt;
   endfunction

   function automatic int first_slot(input int from);
      while (from < NUM_SLOTS && !slot_enabled(from)) from++;
      return from;
   endfunction

   function automatic bit read_outstanding();
      if (m_phase == PH_FILL) return 0;
      if (m_phase == PH_READ) return 1;
      return m_read_pending;
   endfunction

   function automatic void access_of(output logic [31:0] addr, output logic [1:0] sz,
                                     output logic [31:0] val);
      logic [31:0] a, rem;
      int lane, pat;
      a = m_base + {6'd0, m_chunk, 2'b00};
      if (m_phase == PH_FILL || m_phase == PH_READ) begin
         sz = SIZE_WORD;
         val = PAT_FILL;
      end else if (m_phase == PH_WORD) begin
         sz = SIZE_WORD;
         val = m_slot == 5'd0 ? PAT_55 : PAT_AA;
      end else begin
         sz = size_of(m_slot);
         lane = lane_of(m_slot);
         pat = pattern_of(m_slot);
         rem = (word_total() - {8'd0, m_chunk}) << 2;
         if (sz == SIZE_BYTE) begin
            a = a + lane;
            val = pat == 0 ? 32'h55 : (pat == 1 ? 32'hAA : ((rem + 4 - lane) & 32'hFF));
         end else if (sz == SIZE_HALF) begin
            a = a + 2 * lane;
            val = pat == 0 ? 32'h5555 : (pat == 1 ? 32'hAAAA : ((rem + 2 - lane) & 32'hFFFF));
         end else begin
            val = pat == 0 ? PAT_55 : (pat == 1 ? PAT_AA : rem);
         end
      end
      addr = a & ADDR_MASK;
   endfunction

   function automatic bit step_walk();
      bit last;
      last = ({8'd0, m_chunk} + 32'd1) >= word_total();
      if (m_phase == PH_FILL || m_phase == PH_READ) begin
         if (last) begin
            m_phase = m_phase + 2'd1;
            m_chunk = '0;
            m_slot = '0;
            m_read_pending = 1'b0;
         end else m_chunk = m_chunk + 24'd1;
         return 0;
      end
      if (!m_read_pending) begin
         m_read_pending = 1'b1;
         return 0;
      end
      m_read_pending = 1'b0;
      if (m_phase == PH_WORD) begin
         if (m_slot == 5'd0) begin
            m_slot = 5'd1;
            return 0;
         end
         m_slot = '0;
         if (!last) begin
            m_chunk = m_chunk + 24'd1;
            return 0;
         end
         m_phase = PH_CHUNK;
         m_chunk = '0;
         m_slot = 5'(first_slot(0));
         return m_slot >= NUM_SLOTS;
      end
      m_slot = 5'(first_slot(m_slot + 1));
      if (m_slot < NUM_SLOTS) return 0;
      if (last) return 1;
      m_chunk = m_chunk + 24'd1;
      m_slot = 5'(first_slot(0));
      return m_slot >= NUM_SLOTS;
   endfunction

   function automatic command_type finish_cmd();
      m_busy = 1'b0;
      m_phase = PH_FILL;
      m_chunk = '0;
      m_slot = '0;
      m_read_pending = 1'b0;
      return '{CMD_FINISH, 32'd0, SIZE_BYTE, 32'd0, m_errors};
   endfunction

   function automatic command_type next_cmd();
      logic [31:0] addr, val;
      logic [1:0] sz;
      bit rd;
      rd = read_outstanding();
      access_of(addr, sz, val);
      m_expected = val;
      return '{rd ? CMD_READ : CMD_WRITE, addr, sz, rd ? 32'd0 : val, m_errors};
   endfunction

   function automatic bit sequence_step(input logic [1:0] rt, input logic [31:0] data,
                                        output command_type c);
      logic [31:0] addr, val, got;
      logic [1:0] sz;
      bit rd;
      if (rt == REQ_START) begin
         if (m_busy) return 0;
         m_errors = '0;
         m_phase = PH_FILL;
         m_chunk = '0;
         m_slot = '0;
         m_read_pending = 1'b0;
         m_expected = '0;
         if (word_total() == 32'd0) begin
            c = finish_cmd();
            return 1;
         end
         m_busy = 1'b1;
         c = next_cmd();
         return 1;
      end
      if (!m_busy || rt == 2'd3) return 0;
      rd = read_outstanding();
      if ((rt == REQ_READ_DATA) != rd) return 0;
      if (rd) begin
         access_of(addr, sz, val);
         got = sz == SIZE_BYTE ? data & 32'hFF : (sz == SIZE_HALF ? data & 32'hFFFF : data);
         if (got != m_expected && m_errors != 32'hFFFF_FFFF &&
             (m_phase != PH_CHUNK || m_errors < ERROR_LIMIT))
            m_errors++;
      end
      c = step_walk() ? finish_cmd() : next_cmd();
      return 1;
   endfunction

   function automatic void mirror_csr(input logic [2:0] idx, input logic [31:0] v);
      case (idx)
         CSR_BASE:    m_base = v;
         CSR_LENGTH:  m_len = v[26:0];
         CSR_EN_BYTE: m_en_byte = v[0];
         CSR_EN_HALF: m_en_half = v[0];
         CSR_EN_WORD: m_en_word = v[0];
         CSR_EN_CHK:  m_en_chk = v[0];
         CSR_EN_CNT:  m_en_cnt = v[0];
         default: ;
      endcase
   endfunction

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] v);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = v;
      @(negedge clock);
      csr_write_enable = 1'b0;
      mirror_csr(idx, v);
   endtask

   task automatic wait_drained();
      while (cmd_q.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // drive one transfer, queue the predicted answer
   task automatic send(input logic [1:0] rt, input logic [31:0] data, input int chk,
                       input command_type typed);
      command_type c;
      bit has;
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid = 1'b1;
      req_type = rt;
      req_read_data = data;
      do @(posedge clock); while (req_stall);
      has = sequence_step(rt, data, c);
      if (chk == CHK_TYPED) begin
         if (!has) begin
            $error("command: expected %0d, got none predicted", typed.command);
            failures++;
         end
         cmd_q.push_back(typed);
      end else begin
         if (chk == CHK_NONE && has) begin
            $error("command: expected none, predicted %0d", c.command);
            failures++;
         end
         if (has) cmd_q.push_back(c);
      end
      cmd_items++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      command_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cmd_q.size() == 0) begin
            $error("command: unexpected transfer %0d", rsp_command);
            failures++;
         end else begin
            e = cmd_q.pop_front();
            if (rsp_command !== e.command) begin
               $error("command: expected %0d, actual %0d", e.command, rsp_command);
               failures++;
            end
            if (rsp_mem_address !== e.mem_address) begin
               $error("mem_address: expected %h, actual %h", e.mem_address, rsp_mem_address);
               failures++;
            end
            if (rsp_access_size !== e.access_size) begin
               $error("access_size: expected %0d, actual %0d", e.access_size, rsp_access_size);
               failures++;
            end
            if (rsp_write_value !== e.write_value) begin
               $error("write_value: expected %h, actual %h", e.write_value, rsp_write_value);
               failures++;
            end
            if (rsp_error_total !== e.error_total) begin
               $error("error_total: expected %0d, actual %0d", e.error_total, rsp_error_total);
               failures++;
            end
         end
      end
   end

   initial begin
      #40_000_000;
      $display("memory_pattern_test_sequencer_top test failed");
      $finish;
   end

   task automatic add(ref row_type rows[$], input bit is_csr, input logic [2:0] idx,
                      input logic [31:0] val, input logic [1:0] rt, input logic [31:0] data,
                      input int chk, input command_type c);
      row_type r;
      r.is_csr = is_csr;
      r.idx = idx;
      r.val = val;
      r.rtype = rt;
      r.data = data;
      r.chk = chk;
      r.cmd = c;
      rows.push_back(r);
   endtask

   task automatic respond();
      logic [31:0] d;
      logic [31:0] addr, val;
      logic [1:0] sz;
      int pick;
      pick = $urandom_range(99);
      if (pick < 4) send(REQ_START, $urandom, CHK_PREDICT, '0);
      else if (pick < 8) send(read_outstanding() ? REQ_WRITE_DONE : REQ_READ_DATA,
                              $urandom, CHK_PREDICT, '0);
      else if (pick < 10) send(2'd3, $urandom, CHK_PREDICT, '0);
      else if (!read_outstanding()) send(REQ_WRITE_DONE, $urandom, CHK_PREDICT, '0);
      else begin
         access_of(addr, sz, val);
         d = $urandom;
         if ($urandom_range(99) < 75) begin
            if (sz == SIZE_BYTE) d = {d[31:8], m_expected[7:0]};
            else if (sz == SIZE_HALF) d = {d[31:16], m_expected[15:0]};
            else d = m_expected;
         end else if ($urandom_range(1)) d = m_expected ^ (32'd1 << $urandom_range(31));
         send(REQ_READ_DATA, d, CHK_PREDICT, '0);
      end
   endtask

   initial begin
      row_type rows[$];
      int target;
      logic [31:0] v;
      m_base = '0; m_len = '0;
      m_en_byte = 1'b0; m_en_half = 1'b0; m_en_word = 1'b0;
      m_en_chk = 1'b0; m_en_cnt = 1'b0;
      m_busy = 1'b0; m_read_pending = 1'b0; m_phase = PH_FILL; m_chunk = '0; m_slot = '0;
      m_expected = '0; m_errors = '0;
      target = 1250;

      add(rows, 0, 0, 0, REQ_START, 0, CHK_TYPED,
          '{CMD_FINISH, 32'd0, SIZE_BYTE, 32'd0, 32'd0});
      add(rows, 0, 0, 0, REQ_WRITE_DONE, 0, CHK_NONE, '0);
      add(rows, 0, 0, 0, REQ_READ_DATA, 32'hFFFF_FFFF, CHK_NONE, '0);
      add(rows, 1, CSR_BASE, 32'hFFFF_FFF8, 0, 0, CHK_PREDICT, '0);
      add(rows, 1, CSR_LENGTH, 32'hB, 0, 0, CHK_PREDICT, '0);
      add(rows, 1, CSR_EN_BYTE, 1, 0, 0, CHK_PREDICT, '0);
      add(rows, 1, CSR_EN_HALF, 1, 0, 0, CHK_PREDICT, '0);
      add(rows, 1, CSR_EN_WORD, 1, 0, 0, CHK_PREDICT, '0);
      add(rows, 1, CSR_EN_CHK, 1, 0, 0, CHK_PREDICT, '0);
      add(rows, 1, CSR_EN_CNT, 1, 0, 0, CHK_PREDICT, '0);
      add(rows, 0, 0, 0, REQ_START, 0, CHK_TYPED,
          '{CMD_WRITE, 32'hFFFF_FFF8, SIZE_WORD, PAT_FILL, 32'd0});
      add(rows, 0, 0, 0, REQ_START, 0, CHK_NONE, '0);
      add(rows, 0, 0, 0, 2'd3, 0, CHK_NONE, '0);
      add(rows, 0, 0, 0, REQ_READ_DATA, PAT_FILL, CHK_NONE, '0);
      add(rows, 0, 0, 0, REQ_WRITE_DONE, 0, CHK_TYPED,
          '{CMD_WRITE, 32'hFFFF_FFFC, SIZE_WORD, PAT_FILL, 32'd0});
      add(rows, 0, 0, 0, REQ_WRITE_DONE, 0, CHK_TYPED,
          '{CMD_READ, 32'hFFFF_FFF8, SIZE_WORD, 32'd0, 32'd0});
      add(rows, 0, 0, 0, REQ_READ_DATA, 0, CHK_TYPED,
          '{CMD_READ, 32'hFFFF_FFFC, SIZE_WORD, 32'd0, 32'd1});
      add(rows, 0, 0, 0, REQ_READ_DATA, PAT_FILL, CHK_TYPED,
          '{CMD_WRITE, 32'hFFFF_FFF8, SIZE_WORD, PAT_55, 32'd1});
      add(rows, 0, 0, 0, REQ_WRITE_DONE, 0, CHK_TYPED,
          '{CMD_READ, 32'hFFFF_FFF8, SIZE_WORD, 32'd0, 32'd1});
      add(rows, 0, 0, 0, REQ_READ_DATA, 32'hFFFF_FFFF, CHK_PREDICT, '0);
      add(rows, 0, 0, 0, REQ_WRITE_DONE, 0, CHK_PREDICT, '0);
      add(rows, 0, 0, 0, REQ_READ_DATA, PAT_AA, CHK_PREDICT, '0);
      add(rows, 0, 0, 0, REQ_WRITE_DONE, 0, CHK_PREDICT, '0);
      add(rows, 0, 0, 0, REQ_READ_DATA, PAT_55, CHK_PREDICT, '0);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) begin
         if (rows[i].is_csr) begin
            wait_drained();
            write_csr(rows[i].idx, rows[i].val);
         end else send(rows[i].rtype, rows[i].data, rows[i].chk, rows[i].cmd);
      end

      while (cmd_items < target) begin
         if (cmd_items > 2 * target / 3) begin
            send_idle_pct = 0;
            stall_pct = 0;
         end else if (cmd_items > target / 3) begin
            send_idle_pct = 71;
            stall_pct = 28;
         end
         if (!m_busy) begin
            wait_drained();
            case ($urandom_range(5))
               0: v = 32'd0;
               1: v = 32'hFFFF_FFFC;
               default: v = $urandom & 32'hFFFF_FFFC;
            endcase
            write_csr(CSR_BASE, v);
            case ($urandom_range(9))
               0: v = 32'd0;
               1: v = 32'h7FF_FFFF;
               2: v = 32'd3;
               default: v = $urandom_range(40);
            endcase
            write_csr(CSR_LENGTH, v);
            // extreme length is only held, never run
            if (v == 32'h7FF_FFFF) write_csr(CSR_LENGTH, $urandom_range(4, 24));
            write_csr(CSR_EN_BYTE, $urandom);
            write_csr(CSR_EN_HALF, $urandom);
            write_csr(CSR_EN_WORD, $urandom);
            write_csr(CSR_EN_CHK, $urandom);
            write_csr(CSR_EN_CNT, $urandom);
            send(REQ_START, $urandom, CHK_PREDICT, '0);
         end else respond();
      end

      // long region at the top of the address space, left running
      while (m_busy) respond();
      wait_drained();
      write_csr(CSR_BASE, 32'hFFFF_FFFC);
      write_csr(CSR_LENGTH, 32'h7FF_FFFF);
      send(REQ_START, 0, CHK_PREDICT, '0);
      repeat (40) respond();

      while (cmd_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (failures == 0) $display("memory_pattern_test_sequencer_top test passed");
      else $display("memory_pattern_test_sequencer_top test failed");
      $finish;
   end

endmodule
